[rtl/ptw_pkg.sv]
// ptw_pkg: shared types and constants for the four-level page table walker
// holds the item, result and controller/datapath interface types
// no dependencies
package ptw_pkg;

  // table memory geometry
  localparam int MEM_WORDS         = 4096;
  localparam int MEM_AW            = $clog2(MEM_WORDS);
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int LEVEL_BITS        = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_SHIFT        = 12;

  // field widths
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int WIDX_W  = 12;
  localparam int ENTRY_W = 64;
  localparam int EADDR_W = PA_W + 1;   // sum of base and index can carry out
  localparam int WORD_W  = EADDR_W - 3;

  localparam logic [WORD_W-1:0] MEM_WORDS_W = WORD_W'(MEM_WORDS);

  // entry bits
  localparam int PRESENT_POS = 0;
  localparam int HUGE_POS    = 7;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_WALK  = 1'b1;

  // walk levels
  localparam logic [2:0] LVL_NONE = 3'd0;
  localparam logic [2:0] LVL_1    = 3'd1;
  localparam logic [2:0] LVL_2    = 3'd2;
  localparam logic [2:0] LVL_3    = 3'd3;
  localparam logic [2:0] LVL_4    = 3'd4;

  typedef enum logic [2:0] {
    ST_WRITTEN      = 3'd0,
    ST_LEAF         = 3'd1,
    ST_HUGE_1G      = 3'd2,
    ST_HUGE_2M      = 3'd3,
    ST_NOT_PRESENT  = 3'd4,
    ST_ROOT_ZERO    = 3'd5,
    ST_OUT_OF_RANGE = 3'd6
  } status_t;

  typedef struct packed {
    logic                cmd;
    logic [VA_W-1:0]     virtual_address;
    logic [WIDX_W-1:0]   word_index;
    logic [ENTRY_W-1:0]  entry_value;
  } walk_item_t;

  typedef struct packed {
    status_t             status;
    logic [PA_W-1:0]     entry_address;
    logic [2:0]          stop_level;
  } walk_result_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_en;          // write zero at the clear counter
    logic wr_en;           // store the item's entry
    logic walk_load;       // latch address, base from root, level 4
    logic addr_calc;       // register entry address of current level
    logic rd_en;           // read the entry at the registered address
    logic next_level;      // follow entry to the next table
    logic res_written;
    logic res_root_zero;
    logic res_oor;
    logic res_leaf;
    logic res_not_present;
    logic res_huge;
  } ptw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic root_zero;
    logic oor;
    logic last_level;
    logic present;
    logic huge;
  } ptw_stat_t;

endpackage

[rtl/four_level_page_table_walker.sv]
// four_level_page_table_walker: top level of the page table walker
// joins the ptw_ctrl sequencer and the ptw_dp datapath
// depends on ptw_pkg, ptw_ctrl, ptw_dp
//
//   channel   ports                   transfer when
//   -------   ---------------------   ---------------------
//   config    root_we, root_wdata     root_we high
//   item      start, busy, item       start high, busy low
//   result    done, result            done high
//
// a write item, or a walk with a zero root, gives its result in the cycle after
// it is taken; a walk takes each table read through address add, range check
// and read, and entry decode, and a walk that reaches the last level ends there
// after address add and range check. after reset busy stays high while the
// memory is swept to zero; root writes are taken during that time. the receiver
// cannot stall.
module four_level_page_table_walker import ptw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             root_we,
  input  logic [PA_W-1:0]  root_wdata,
  input  logic             start,
  output logic             busy,
  input  walk_item_t       item,
  output logic             done,
  output walk_result_t     result
);

  ptw_cmd_t  ctl;
  ptw_stat_t stat;

  // sequencer
  ptw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (item.cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // datapath
  ptw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .root_we    (root_we),
    .root_wdata (root_wdata),
    .item       (item),
    .ctl        (ctl),
    .stat       (stat),
    .done       (done),
    .result     (result)
  );

endmodule

[rtl/ptw_ctrl.sv]
// ptw_ctrl: walk sequencer state machine
// issues datapath commands from datapath status flags
// depends on ptw_pkg
module ptw_ctrl import ptw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       cmd,
  input  ptw_stat_t  stat,
  output ptw_cmd_t   ctl,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_CALC   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_WRITE) begin
            ctl.wr_en       = 1'b1;
            ctl.res_written = 1'b1;
          end else if (stat.root_zero) begin
            ctl.res_root_zero = 1'b1;
          end else begin
            ctl.walk_load = 1'b1;
            state_next    = S_CALC;
          end
        end
      end
      S_CALC: begin
        ctl.addr_calc = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (stat.oor) begin
          ctl.res_oor = 1'b1;
          state_next  = S_IDLE;
        end else if (stat.last_level) begin
          ctl.res_leaf = 1'b1;
          state_next   = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.present) begin
          ctl.res_not_present = 1'b1;
          state_next          = S_IDLE;
        end else if (stat.huge) begin
          ctl.res_huge = 1'b1;
          state_next   = S_IDLE;
        end else begin
          ctl.next_level = 1'b1;
          state_next     = S_CALC;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[rtl/ptw_dp.sv]
// ptw_dp: walker datapath with table memory, address unit and result registers
// executes commands from ptw_ctrl and reports status flags
// depends on ptw_pkg
module ptw_dp import ptw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             root_we,
  input  logic [PA_W-1:0]  root_wdata,
  input  walk_item_t       item,
  input  ptw_cmd_t         ctl,
  output ptw_stat_t        stat,
  output logic             done,
  output walk_result_t     result
);

  logic [ENTRY_W-1:0] mem [MEM_WORDS];

  logic [PA_W-1:0]    root;
  logic [VA_W-1:0]    va;
  logic [PA_W-1:0]    base;
  logic [2:0]         level;
  logic [EADDR_W-1:0] eaddr;
  logic [ENTRY_W-1:0] rdata;
  logic [MEM_AW-1:0]  clr_cnt;

  logic [LEVEL_BITS-1:0] idx;
  logic [WORD_W-1:0]     word;
  logic [WORD_W-1:0]     widx_ext;
  logic                  mem_we;
  logic [MEM_AW-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;

  // root register
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (root_we) begin
      root <= root_wdata;
    end
  end

  // clear counter for the post-reset sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // index bits of the current level
  always_comb begin
    case (level)
      LVL_4:   idx = va[PAGE_SHIFT + 3*LEVEL_BITS +: LEVEL_BITS];
      LVL_3:   idx = va[PAGE_SHIFT + 2*LEVEL_BITS +: LEVEL_BITS];
      LVL_2:   idx = va[PAGE_SHIFT + LEVEL_BITS +: LEVEL_BITS];
      default: idx = va[PAGE_SHIFT +: LEVEL_BITS];
    endcase
  end

  assign word     = eaddr[EADDR_W-1:3];
  assign widx_ext = WORD_W'(item.word_index);

  // walk registers
  always_ff @(posedge clk) begin
    if (ctl.walk_load) begin
      va    <= item.virtual_address;
      base  <= root;
      level <= LVL_4;
    end else if (ctl.next_level) begin
      base  <= {rdata[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      level <= level - 1'b1;
    end
    if (ctl.addr_calc) begin
      eaddr <= EADDR_W'(base) + EADDR_W'({idx, 3'b000});
    end
  end

  // memory write port, shared by the clear sweep and write items
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    if (ctl.clr_en) begin
      mem_we = 1'b1;
    end else if (ctl.wr_en && (widx_ext < MEM_WORDS_W)) begin
      mem_we    = 1'b1;
      mem_waddr = widx_ext[MEM_AW-1:0];
      mem_wdata = item.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered entry read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[word[MEM_AW-1:0]];
    end
  end

  // status flags
  always_comb begin
    stat.clr_last   = (clr_cnt == MEM_AW'(MEM_WORDS - 1));
    stat.root_zero  = (root == '0);
    stat.oor        = (word >= MEM_WORDS_W);
    stat.last_level = (level == LVL_1);
    stat.present    = rdata[PRESENT_POS];
    stat.huge       = rdata[HUGE_POS] && (level != LVL_4);
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.res_written | ctl.res_root_zero | ctl.res_oor | ctl.res_leaf |
              ctl.res_not_present | ctl.res_huge;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.res_written) begin
      result.status        <= ST_WRITTEN;
      result.entry_address <= '0;
      result.stop_level    <= LVL_NONE;
    end else if (ctl.res_root_zero) begin
      result.status        <= ST_ROOT_ZERO;
      result.entry_address <= '0;
      result.stop_level    <= LVL_4;
    end else if (ctl.res_oor) begin
      result.status        <= ST_OUT_OF_RANGE;
      result.entry_address <= '0;
      result.stop_level    <= level;
    end else if (ctl.res_leaf) begin
      result.status        <= ST_LEAF;
      result.entry_address <= eaddr[PA_W-1:0];
      result.stop_level    <= LVL_1;
    end else if (ctl.res_not_present) begin
      result.status        <= ST_NOT_PRESENT;
      result.entry_address <= '0;
      result.stop_level    <= level;
    end else if (ctl.res_huge) begin
      result.status        <= (level == LVL_3) ? ST_HUGE_1G : ST_HUGE_2M;
      result.entry_address <= eaddr[PA_W-1:0];
      result.stop_level    <= level;
    end
  end

endmodule
